// ===== sv/bsed_pkg.sv =====
// ----------------------------------------------------------------------------
// bsed_pkg
// Shared types, character codes and lookup functions for the escape decoder.
// ----------------------------------------------------------------------------
package bsed_pkg;

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_HEX1 = 2'd2;
  localparam logic [1:0] PH_HEX2 = 2'd3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_V  = 8'h76;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  localparam logic [7:0] CODE_BEL = 8'h07;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_HT  = 8'h09;
  localparam logic [7:0] CODE_VT  = 8'h0B;

  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] high_nibble;
    logic       error_seen;
  } bsed_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       error;
  } bsed_result_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] value;
  } bsed_lookup_t;

  function automatic bsed_lookup_t hex_value(input logic [7:0] c);
    bsed_lookup_t r;
    r = '0;
    if (c inside {[CH_DIG_0:CH_DIG_9]}) begin
      r.ok    = 1'b1;
      r.value = c - CH_DIG_0;
    end else if (c inside {[CH_LOW_A:CH_LOW_F]}) begin
      r.ok    = 1'b1;
      r.value = c - CH_LOW_A + 8'd10;
    end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
      r.ok    = 1'b1;
      r.value = c - CH_UP_A + 8'd10;
    end
    return r;
  endfunction

  function automatic bsed_lookup_t simple_escape(input logic [7:0] c);
    bsed_lookup_t r;
    r.ok = 1'b1;
    case (c)
      CH_DQUOTE: r.value = CH_DQUOTE;
      CH_SQUOTE: r.value = CH_SQUOTE;
      CH_BSLASH: r.value = CH_BSLASH;
      CH_LOW_A:  r.value = CODE_BEL;
      CH_LOW_B:  r.value = CODE_BS;
      CH_LOW_F:  r.value = CODE_FF;
      CH_LOW_N:  r.value = CODE_LF;
      CH_LOW_R:  r.value = CODE_CR;
      CH_LOW_T:  r.value = CODE_HT;
      CH_LOW_V:  r.value = CODE_VT;
      default: begin
        r.ok    = 1'b0;
        r.value = 8'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== sv/backslash_escape_decoder_core.sv =====
// ----------------------------------------------------------------------------
// backslash_escape_decoder_core
// Decodes C style backslash escapes in a byte stream, one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake          | payload
//   in_      | input     | in_valid/in_stall  | in_byte, in_end_of_string
//   out_     | output    | out_valid/out_stall| out_byte, out_last, out_error
//
// Each transaction is registered, decoded combinationally and its result, if
// any, lands in the output register: one byte per cycle while the output does not stall.
// Throughput is set by the single decode step between the two registers.
// A stall on the output holds the input register and in turn raises in_stall.
// Reset (rst_n low, synchronous) returns the decoder to plain text state.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_core import bsed_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_error
);

  logic         in_valid_r, in_valid_nxt;
  logic [7:0]   byte_r;
  logic         eos_r;
  bsed_state_t  st_r, st_nxt;
  bsed_result_t res;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_byte_r;
  logic         out_last_r;
  logic         out_error_r;
  logic         out_free;
  logic         proc;
  logic         in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign proc     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  bsed_decode u_decode (
    .st     (st_r),
    .c      (byte_r),
    .eos    (eos_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign in_valid_nxt  = in_take ? 1'b1 : (proc ? 1'b0 : in_valid_r);
  assign out_valid_nxt = proc ? res.valid : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (proc) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_byte;
      eos_r  <= in_end_of_string;
    end
    if (proc && res.valid) begin
      out_byte_r  <= res.data;
      out_last_r  <= res.last;
      out_error_r <= res.error;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res.valid && res.last) |=> (st_r == '0))
    else $error("State not cleared after the final result of a string.");

  a_error_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_last && out_byte == 8'd0))
    else $error("Error result is not a zero byte marked last.");

  a_swallow_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && st_r.error_seen && !eos_r) |=> !out_valid)
    else $error("Result produced while swallowing bytes after an error.");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r))
    else $error("Input stalled without a pending transaction.");

endmodule

// ===== sv/bsed_decode.sv =====
// ----------------------------------------------------------------------------
// bsed_decode
// Combinational escape decoding step: next state and optional result.
// ----------------------------------------------------------------------------
module bsed_decode import bsed_pkg::*; (
  input  bsed_state_t  st,
  input  logic [7:0]   c,
  input  logic         eos,
  output bsed_state_t  st_nxt,
  output bsed_result_t res
);

  bsed_lookup_t hex;
  bsed_lookup_t simp;

  assign hex  = hex_value(c);
  assign simp = simple_escape(c);

  always_comb begin
    logic do_fail;
    st_nxt  = st;
    res     = '0;
    do_fail = 1'b0;
    if (st.error_seen) begin
      if (eos) begin
        res = '{valid: 1'b1, data: 8'd0, last: 1'b1, error: 1'b1};
      end
    end else begin
      case (st.phase)
        PH_TEXT: begin
          if (c == CH_BSLASH && !eos) begin
            st_nxt.phase = PH_ESC;
          end else begin
            res = '{valid: 1'b1, data: c, last: eos, error: 1'b0};
          end
        end
        PH_ESC: begin
          if (c == CH_LOW_X || c == CH_UP_X) begin
            if (eos) do_fail = 1'b1;
            else st_nxt.phase = PH_HEX1;
          end else if (simp.ok) begin
            st_nxt.phase = PH_TEXT;
            res = '{valid: 1'b1, data: simp.value, last: eos, error: 1'b0};
          end else begin
            do_fail = 1'b1;
          end
        end
        PH_HEX1: begin
          if (!hex.ok || eos) begin
            do_fail = 1'b1;
          end else begin
            st_nxt.high_nibble = hex.value[3:0];
            st_nxt.phase       = PH_HEX2;
          end
        end
        PH_HEX2: begin
          if (!hex.ok) begin
            do_fail = 1'b1;
          end else begin
            st_nxt.phase       = PH_TEXT;
            st_nxt.high_nibble = 4'd0;
            res = '{valid: 1'b1, data: {st.high_nibble, hex.value[3:0]},
                    last: eos, error: 1'b0};
          end
        end
        default: st_nxt = '0;
      endcase
      if (do_fail) begin
        if (eos) begin
          res = '{valid: 1'b1, data: 8'd0, last: 1'b1, error: 1'b1};
        end else begin
          st_nxt = '{phase: PH_TEXT, high_nibble: 4'd0, error_seen: 1'b1};
        end
      end
    end
    if (res.valid && res.last) st_nxt = '0;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escape decoder testbench
// Drives escaped strings into backslash_escape_decoder_core: a directed set
// of escapes, hex sequences and malformed strings, then random strings built
// from plain bytes and well-formed escapes with some broken ones mixed in. Both
// channels idle at random. The receiver also holds off once for a long
// stretch. A scoreboard decodes every accepted transaction on its own and
// checks each result against the oldest decoded byte it holds.
// ----------------------------------------------------------------------------
module testbench import bsed_pkg::*; ();

  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_AT      = 300;
  localparam int CALM_FROM    = 500;
  localparam int CALM_TO      = 750;

  class unescape_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
    } decoded_t;

    logic [1:0] phase;
    logic [3:0] nibble;
    logic       bad_string;
    decoded_t   decoded_q[$];
    int         mismatches;

    function new();
      phase      = PH_TEXT;
      nibble     = 4'd0;
      bad_string = 1'b0;
      mismatches = 0;
    endfunction

    function void queue_result(logic [7:0] data, logic last, logic err);
      decoded_t d;
      d.data = data;
      d.last = last;
      d.err  = err;
      decoded_q.push_back(d);
      if (last) begin
        phase      = PH_TEXT;
        nibble     = 4'd0;
        bad_string = 1'b0;
      end
    endfunction

    // A malformed escape is reported at the end of the string only.
    function void mark_malformed(logic eos);
      if (eos) begin
        queue_result(8'd0, 1'b1, 1'b1);
      end else begin
        bad_string = 1'b1;
        phase      = PH_TEXT;
        nibble     = 4'd0;
      end
    endfunction

    function void note_input(logic [7:0] c, logic eos);
      logic       is_hex;
      logic [3:0] digit;
      logic       is_simple;
      logic [7:0] code;
      is_hex = 1'b1;
      if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
        digit = 4'(c - CH_DIG_0);
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
        digit = 4'(c - CH_LOW_A + 8'd10);
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
        digit = 4'(c - CH_UP_A + 8'd10);
      end else begin
        is_hex = 1'b0;
        digit  = 4'd0;
      end
      is_simple = 1'b1;
      case (c)
        CH_DQUOTE: code = CH_DQUOTE;
        CH_SQUOTE: code = CH_SQUOTE;
        CH_BSLASH: code = CH_BSLASH;
        CH_LOW_A:  code = CODE_BEL;
        CH_LOW_B:  code = CODE_BS;
        CH_LOW_F:  code = CODE_FF;
        CH_LOW_N:  code = CODE_LF;
        CH_LOW_R:  code = CODE_CR;
        CH_LOW_T:  code = CODE_HT;
        CH_LOW_V:  code = CODE_VT;
        default: begin
          is_simple = 1'b0;
          code      = 8'd0;
        end
      endcase
      if (bad_string) begin
        if (eos) queue_result(8'd0, 1'b1, 1'b1);
        return;
      end
      case (phase)
        PH_TEXT: begin
          if (c == CH_BSLASH && !eos) phase = PH_ESC;
          else queue_result(c, eos, 1'b0);
        end
        PH_ESC: begin
          if (c == CH_LOW_X || c == CH_UP_X) begin
            if (eos) mark_malformed(eos);
            else phase = PH_HEX1;
          end else if (!is_simple) begin
            mark_malformed(eos);
          end else begin
            phase = PH_TEXT;
            queue_result(code, eos, 1'b0);
          end
        end
        PH_HEX1: begin
          if (!is_hex || eos) begin
            mark_malformed(eos);
          end else begin
            nibble = digit;
            phase  = PH_HEX2;
          end
        end
        default: begin
          if (!is_hex) begin
            mark_malformed(eos);
          end else begin
            phase = PH_TEXT;
            queue_result({nibble, digit}, eos, 1'b0);
            nibble = 4'd0;
          end
        end
      endcase
    endfunction

    function void check_result(logic [7:0] data, logic last, logic err);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: byte=%02h last=%0b error=%0b",
                   $realtime, data, last, err);
        return;
      end
      want = decoded_q.pop_front();
      if (want.data !== data || want.last !== last || want.err !== err) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] mismatch: expected byte=%02h last=%0b error=%0b,",
                    " got byte=%02h last=%0b error=%0b"},
                   $realtime, want.data, want.last, want.err, data, last, err);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_end_of_string;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  unescape_scoreboard decoder_sb;
  logic [7:0] line_q[$];
  int         inputs_taken;
  int         quiet_cycles = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  backslash_escape_decoder_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_error        (out_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit take_break();
    if (inputs_taken >= CALM_FROM && inputs_taken < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < 29;
  endfunction

  task automatic drive_item(logic [7:0] b, logic eos);
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decoder_sb.note_input(b, eos);
    inputs_taken++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++)
      drive_item(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_DIG_0 + 8'(v);
    if ($urandom_range(0, 1) == 0) return CH_LOW_A + 8'(v - 10);
    return CH_UP_A + 8'(v - 10);
  endfunction

  task automatic make_random_line();
    int tokens;
    int kind;
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        line_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 60) begin
        line_q.push_back(CH_BSLASH);
        case ($urandom_range(0, 9))
          0: line_q.push_back(CH_DQUOTE);
          1: line_q.push_back(CH_SQUOTE);
          2: line_q.push_back(CH_BSLASH);
          3: line_q.push_back(CH_LOW_A);
          4: line_q.push_back(CH_LOW_B);
          5: line_q.push_back(CH_LOW_F);
          6: line_q.push_back(CH_LOW_N);
          7: line_q.push_back(CH_LOW_R);
          8: line_q.push_back(CH_LOW_T);
          default: line_q.push_back(CH_LOW_V);
        endcase
      end else if (kind < 85) begin
        line_q.push_back(CH_BSLASH);
        line_q.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LOW_X);
        line_q.push_back(random_hex_char());
        line_q.push_back(random_hex_char());
      end else begin
        line_q.push_back(CH_BSLASH);
        line_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) line_q.push_back(CH_BSLASH);
    else if ($urandom_range(0, 9) == 0 && line_q.size() > 1) void'(line_q.pop_back());
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && inputs_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= take_break();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      decoder_sb.check_result(out_byte, out_last, out_error);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    decoder_sb       = new();
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_byte          = 8'd0;
    in_end_of_string = 1'b0;
    inputs_taken     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    line_q = '{8'h00, 8'hFF};
    send_line();
    line_q = '{CH_BSLASH, CH_DQUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_LOW_N,
               CH_BSLASH, CH_LOW_V};
    send_line();
    line_q = '{CH_BSLASH, CH_UP_X, CH_LOW_A, CH_UP_F};
    send_line();
    line_q = '{CH_BSLASH};
    send_line();
    line_q = '{CH_BSLASH, 8'h71};
    send_line();
    line_q = '{CH_BSLASH, CH_LOW_X, 8'h33, 8'h67, 8'h5A};
    send_line();
    line_q = '{CH_BSLASH, CH_UP_X};
    send_line();
    line_q = '{CH_BSLASH, CH_LOW_X, 8'h35};
    send_line();

    while (inputs_taken < RANDOM_ITEMS) begin
      make_random_line();
      send_line();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (decoder_sb.decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoder_sb.mismatches == 0 && decoder_sb.decoded_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bsed_pkg.sv
sv/bsed_decode.sv
sv/backslash_escape_decoder_core.sv
dv/testbench.sv
